// File: design/batch_norm_inference_defines.svh
// Assertion macros shared by the batch normalisation checker.
`ifndef BATCH_NORM_INFERENCE_DEFINES_SVH
`define BATCH_NORM_INFERENCE_DEFINES_SVH

// Same-cycle implication, clocked on the rising edge, off while dis is high.
`define BNI_ASSERT_SAME(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on the rising edge, off while dis is high.
`define BNI_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bni_pkg.sv
// Shared constants, types and helpers for the batch normalisation block.
package bni_pkg;

  // Fixed field and register widths
  localparam int FRAC_W     = 16;
  localparam int CH_FIELD_W = 10;
  localparam int NCH_CFG_W  = 11;
  localparam int NSP_CFG_W  = 21;
  localparam int EPS_W      = 16;
  localparam int AVG_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int SP_POS_W   = 20;

  // Parameter defaults
  localparam int DEF_MAX_CHANNELS = 1024;
  localparam int DEF_DATA_WIDTH   = 32;

  // Largest plane size honoured
  localparam logic [NSP_CFG_W-1:0] SPATIAL_LIMIT = 21'h100000;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EPS          = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_FACTOR   = 2'd3;

  // Register reset values
  localparam logic [NCH_CFG_W-1:0] RST_NUM_CHANNELS = 11'd1;
  localparam logic [NSP_CFG_W-1:0] RST_SPATIAL_SIZE = 21'd1;
  localparam logic [EPS_W-1:0]     RST_EPS          = 16'd1;
  localparam logic [AVG_W-1:0]     RST_AVG_FACTOR   = 32'h0001_0000;

  // Input word function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV1,
    ST_SUM,
    ST_ROOT,
    ST_DIV2,
    ST_DONE
  } st_t;

  // Stream data widths, rounded up to whole bytes
  function automatic int s_tdata_w(input int dw);
    return ((CH_FIELD_W + 3 * dw + 7) / 8) * 8;
  endfunction

  function automatic int m_tdata_w(input int dw);
    return ((dw + CH_FIELD_W + 7) / 8) * 8;
  endfunction

endpackage

// File: design/bni_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bni_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/bni_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module bni_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [NUM_W-1:0] acc_next;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic             last;

  assign last = (cnt == CNT_W'(NUM_W - 1));

  // Shift the next dividend bit into the remainder and try the subtract
  always_comb begin
    rem_sh   = {rem, acc[NUM_W-1]};
    trial    = rem_sh - {1'b0, den_r};
    fits     = !trial[DEN_W];
    rem_next = fits ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    acc_next = {acc[NUM_W-2:0], fits};
  end

  // Control: busy until the last quotient bit, done pulses once the quotient is complete
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  // Dividend shifts out at the top as quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      rem   <= '0;
      den_r <= den;
      cnt   <= '0;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
  end

  assign quo = acc;

endmodule

// File: design/bni_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module bni_sqrt #(
  parameter int IN_W = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [IN_W-1:0]     radicand,
  output logic                done,
  output logic [IN_W/2-1:0]   root
);

  localparam int RT_W  = IN_W / 2;
  localparam int CNT_W = $clog2(RT_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [IN_W-1:0]  vsh;
  logic [RT_W:0]    rem;
  logic [RT_W:0]    rem_next;
  logic [RT_W+2:0]  rem_sh;
  logic [RT_W+2:0]  diff;
  logic             fits;
  logic             last;

  assign last = (cnt == CNT_W'(RT_W - 1));

  // Bring down two bits and test the trial root 4r+1
  always_comb begin
    rem_sh   = {rem, vsh[IN_W-1:IN_W-2]};
    diff     = rem_sh - {1'b0, root, 2'b01};
    fits     = !diff[RT_W+2];
    rem_next = fits ? diff[RT_W:0] : rem_sh[RT_W:0];
  end

  // Control: busy until the last root bit, done pulses with the root complete
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && last;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
      end
    end
  end

  // Radicand shifts out two bits a cycle, root grows one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      vsh  <= radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      vsh  <= {vsh[IN_W-3:0], 2'b00};
      rem  <= rem_next;
      root <= {root[RT_W-2:0], fits};
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

// File: design/batch_norm_inference.sv
// Batch normalisation (inference) top level: (x - mean) / sqrt(var + eps) in Q16.16.
// Load words are taken in the idle state and leave the block ready for the next word.
// A sample word steps through ST_READ, ST_DIV1 (mean and variance divided in parallel),
// ST_SUM, ST_ROOT and ST_DIV2 (centred sample over the root) to ST_DONE; a zero factor
// skips ST_DIV1, a zero root skips ST_DIV2. The next word can be taken in the first
// cycle the result word is offered.
// rst is synchronous: configuration registers return to defaults, counters clear, statistics RAM is kept.
module batch_norm_inference
  import bni_pkg::*;
#(
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int DATA_WIDTH   = DEF_DATA_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_wdata,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: load_channel, mean_sum, var_sum, sample (lowest bits first)
  input  logic [s_tdata_w(DATA_WIDTH)-1:0]    s_axis_tdata,
  // tuser: func
  input  logic                                s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: normalized, sample_channel (lowest bits first)
  output logic [m_tdata_w(DATA_WIDTH)-1:0]    m_axis_tdata,
  // tuser: saturated
  output logic                                m_axis_tuser
);

  localparam int DW        = DATA_WIDTH;
  localparam int CH_AW     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NC_W      = (CH_AW + 1 > NCH_CFG_W) ? CH_AW + 1 : NCH_CFG_W;
  localparam int NUM_W     = DW + FRAC_W + 1;
  localparam int DEN_W     = (DW > AVG_W) ? DW : AVG_W;
  localparam int SQ_IN_W   = 2 * ((DW + FRAC_W + 1) / 2);
  localparam int RT_W      = SQ_IN_W / 2;
  localparam int M_TDATA_W = m_tdata_w(DATA_WIDTH);

  localparam logic [NUM_W-1:0] POS_LIM = NUM_W'({(DW-1){1'b1}});
  localparam logic [NUM_W-1:0] NEG_LIM = POS_LIM + NUM_W'(1);
  localparam logic [DW-1:0]    DMAX    = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]    DMIN    = {1'b1, {(DW-1){1'b0}}};

  // Saturate a signed magnitude to the data range; top bit is the clip flag
  function automatic logic [DW:0] sat_mag(input logic neg, input logic [NUM_W-1:0] q);
    logic [DW:0] r;
    if (neg) begin
      r = (q > NEG_LIM) ? {1'b1, DMIN} : {1'b0, -q[DW-1:0]};
    end else begin
      r = (q > POS_LIM) ? {1'b1, DMAX} : {1'b0, q[DW-1:0]};
    end
    return r;
  endfunction

  // configuration registers
  logic [NCH_CFG_W-1:0] num_channels;
  logic [NSP_CFG_W-1:0] spatial_size;
  logic [EPS_W-1:0]     eps;
  logic [AVG_W-1:0]     avg_factor;

  // position counters
  logic [SP_POS_W-1:0]  spatial_pos;
  logic [CH_AW-1:0]     channel_pos;

  st_t state;
  st_t state_next;

  // input word fields
  logic                  in_func;
  logic [CH_FIELD_W-1:0] in_load_channel;
  logic [DW-1:0]         in_mean_sum;
  logic [DW-1:0]         in_var_sum;
  logic [DW-1:0]         in_sample;
  logic                  s_accept;
  logic                  load_ok;

  // statistics RAM
  logic                  ram_we;
  logic [2*DW-1:0]       ram_rdata;
  logic [DW-1:0]         mean_raw;
  logic [DW-1:0]         var_raw;
  logic [DW-1:0]         mean_mag;

  // per-sample datapath registers
  logic [DW-1:0]         sample_r;
  logic [CH_AW-1:0]      chan_r;
  logic                  mean_neg;
  logic [DW-1:0]         mean_val;
  logic [DW-1:0]         var_val;
  logic [DW:0]           diff_mag;
  logic                  diff_neg;
  logic [DW-1:0]         res;
  logic                  flag;

  // arithmetic units
  logic                  div_a_start;
  logic [NUM_W-1:0]      div_a_num;
  logic [DEN_W-1:0]      div_a_den;
  logic                  div_a_done;
  logic [NUM_W-1:0]      div_a_quo;
  logic                  div_b_start;
  logic                  div_b_done;
  logic [NUM_W-1:0]      div_b_quo;
  logic                  root_start;
  logic                  root_done;
  logic [RT_W-1:0]       root;

  // combinational helpers
  logic [NC_W-1:0]       nch;
  logic [NSP_CFG_W-1:0]  nsp;
  logic [NSP_CFG_W-1:0]  sp_inc;
  logic [NC_W-1:0]       ch_inc;
  logic [DW:0]           mean_sat;
  logic                  var_ovf;
  logic [DW:0]           var_sum_eps;
  logic [DW-1:0]         s_sat;
  logic [DW:0]           diff;
  logic [DW:0]           q_sat;
  logic                  out_free;

  // Unpack the input word
  assign in_func         = s_axis_tuser;
  assign in_load_channel = s_axis_tdata[CH_FIELD_W-1:0];
  assign in_mean_sum     = s_axis_tdata[CH_FIELD_W +: DW];
  assign in_var_sum      = s_axis_tdata[CH_FIELD_W + DW +: DW];
  assign in_sample       = s_axis_tdata[CH_FIELD_W + 2*DW +: DW];

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign load_ok  = (NC_W'(in_load_channel) < NC_W'(MAX_CHANNELS));
  assign ram_we   = s_accept && (in_func == FUNC_LOAD) && load_ok;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Statistics store: mean in the low half, variance in the high half
  bni_ram #(
    .WIDTH (2 * DW),
    .DEPTH (MAX_CHANNELS)
  ) u_bni_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (CH_AW'(in_load_channel)),
    .wdata ({in_var_sum, in_mean_sum}),
    .raddr (channel_pos),
    .rdata (ram_rdata)
  );

  assign mean_raw = ram_rdata[DW-1:0];
  assign var_raw  = ram_rdata[2*DW-1:DW];
  assign mean_mag = mean_raw[DW-1] ? -mean_raw : mean_raw;

  // Divider A serves the mean, then the final quotient
  assign div_a_num = (state == ST_READ) ? {1'b0, mean_mag, FRAC_W'(0)}
                                        : {diff_mag, FRAC_W'(0)};
  assign div_a_den = (state == ST_READ) ? DEN_W'(avg_factor) : DEN_W'(root);

  bni_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_bni_div_a (
    .clk   (clk),
    .rst   (rst),
    .start (div_a_start),
    .num   (div_a_num),
    .den   (div_a_den),
    .done  (div_a_done),
    .quo   (div_a_quo)
  );

  // Divider B scales the variance alongside the mean
  bni_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_bni_div_b (
    .clk   (clk),
    .rst   (rst),
    .start (div_b_start),
    .num   ({1'b0, var_raw, FRAC_W'(0)}),
    .den   (DEN_W'(avg_factor)),
    .done  (div_b_done),
    .quo   (div_b_quo)
  );

  // Offset variance, clip to the unsigned range, root of s in Q16.16
  assign var_sum_eps = {1'b0, var_val} + (DW + 1)'(eps);
  assign s_sat       = var_sum_eps[DW] ? '1 : var_sum_eps[DW-1:0];

  bni_sqrt #(
    .IN_W (SQ_IN_W)
  ) u_bni_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (SQ_IN_W'({s_sat, FRAC_W'(0)})),
    .done     (root_done),
    .root     (root)
  );

  // Saturation of quotients and the centred sample
  assign mean_sat = sat_mag(mean_neg, div_a_quo);
  assign var_ovf  = |div_b_quo[NUM_W-1:DW];
  assign q_sat    = sat_mag(diff_neg, div_a_quo);
  assign diff     = {sample_r[DW-1], sample_r} - {mean_val[DW-1], mean_val};

  // Effective bounds for the position counters
  always_comb begin
    if (num_channels == '0) begin
      nch = NC_W'(1);
    end else if (NC_W'(num_channels) > NC_W'(MAX_CHANNELS)) begin
      nch = NC_W'(MAX_CHANNELS);
    end else begin
      nch = NC_W'(num_channels);
    end
    if (spatial_size == '0) begin
      nsp = NSP_CFG_W'(1);
    end else if (spatial_size > SPATIAL_LIMIT) begin
      nsp = SPATIAL_LIMIT;
    end else begin
      nsp = spatial_size;
    end
    sp_inc = NSP_CFG_W'(spatial_pos) + NSP_CFG_W'(1);
    ch_inc = NC_W'(channel_pos) + NC_W'(1);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_channels <= RST_NUM_CHANNELS;
      spatial_size <= RST_SPATIAL_SIZE;
      eps          <= RST_EPS;
      avg_factor   <= RST_AVG_FACTOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_CHANNELS: num_channels <= cfg_wdata[NCH_CFG_W-1:0];
        REG_SPATIAL_SIZE: spatial_size <= cfg_wdata[NSP_CFG_W-1:0];
        REG_EPS:          eps          <= cfg_wdata[EPS_W-1:0];
        REG_AVG_FACTOR:   avg_factor   <= cfg_wdata[AVG_W-1:0];
      endcase
    end
  end

  // Position counters: restart on a load, advance on a sample
  always_ff @(posedge clk) begin
    if (rst) begin
      spatial_pos <= '0;
      channel_pos <= '0;
    end else if (s_accept) begin
      if (in_func == FUNC_LOAD) begin
        spatial_pos <= '0;
        channel_pos <= '0;
      end else if (sp_inc >= nsp) begin
        spatial_pos <= '0;
        channel_pos <= (ch_inc >= nch) ? '0 : ch_inc[CH_AW-1:0];
      end else begin
        spatial_pos <= sp_inc[SP_POS_W-1:0];
      end
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit starts
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    div_a_start   = 1'b0;
    div_b_start   = 1'b0;
    root_start    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && (in_func == FUNC_SAMPLE)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (avg_factor == '0) begin
          state_next = ST_SUM;
        end else begin
          div_a_start = 1'b1;
          div_b_start = 1'b1;
          state_next  = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_a_done && div_b_done) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        root_start = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) begin
          if (root == '0) begin
            state_next = ST_DONE;
          end else begin
            div_a_start = 1'b1;
            state_next  = ST_DIV2;
          end
        end
      end
      ST_DIV2: begin
        if (div_a_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Per-sample datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        sample_r <= in_sample;
        chan_r   <= channel_pos;
      end
      ST_READ: begin
        flag     <= 1'b0;
        mean_neg <= mean_raw[DW-1];
        if (avg_factor == '0) begin
          mean_val <= '0;
          var_val  <= '0;
        end
      end
      ST_DIV1: begin
        if (div_a_done && div_b_done) begin
          mean_val <= mean_sat[DW-1:0];
          var_val  <= var_ovf ? '1 : div_b_quo[DW-1:0];
          flag     <= flag | mean_sat[DW] | var_ovf;
        end
      end
      ST_SUM: begin
        flag     <= flag | var_sum_eps[DW];
        diff_neg <= diff[DW];
        diff_mag <= diff[DW] ? -diff : diff;
      end
      ST_ROOT: begin
        // zero divisor: clip by the sign of the centred sample
        if (root_done && (root == '0)) begin
          flag <= 1'b1;
          if (diff_neg) begin
            res <= DMIN;
          end else if (diff_mag != '0) begin
            res <= DMAX;
          end else begin
            res <= '0;
          end
        end
      end
      ST_DIV2: begin
        if (div_a_done) begin
          res  <= q_sat[DW-1:0];
          flag <= flag | q_sat[DW];
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Result register: hold until taken, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      m_axis_tdata <= M_TDATA_W'({CH_FIELD_W'(chan_r), res});
      m_axis_tuser <= flag;
    end
  end

endmodule

// File: design/bni_checker.sv
// Port-level checker for the batch normalisation block, bound to the top level.
`include "batch_norm_inference_defines.svh"

module bni_checker
  import bni_pkg::*;
#(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [m_tdata_w(DATA_WIDTH)-1:0] m_axis_tdata
);

  logic s_acc;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // Reset empties the result register
  `BNI_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !m_axis_tvalid, "result valid after reset")

  // A sample occupies the block, so no word is taken right after it
  `BNI_ASSERT_NEXT(a_sample_busy, clk, rst, s_acc && (s_axis_tuser == FUNC_SAMPLE), !s_axis_tready, "word taken while a sample is in work")

  // A load completes at once and leaves the block ready
  `BNI_ASSERT_NEXT(a_load_ready, clk, rst, s_acc && (s_axis_tuser == FUNC_LOAD), s_axis_tready, "block not ready after a load")

  // No result can appear the cycle after a word is taken
  `BNI_ASSERT_SAME(a_no_instant, clk, rst, $rose(m_axis_tvalid), !$past(s_acc), "result too soon after input")

  // A stalled result holds
  `BNI_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

endmodule

bind batch_norm_inference bni_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_bni_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
